// ===== sv/hysteresis_comparator_edge_irq_top_macros.svh =====
// ----------------------------------------------------------------------------
// Hysteresis comparator assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef HYSTERESIS_COMPARATOR_EDGE_IRQ_TOP_MACROS_SVH
`define HYSTERESIS_COMPARATOR_EDGE_IRQ_TOP_MACROS_SVH

`ifndef SYNTHESIS
// clocked on clk_i, disabled during reset
`define HCE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("hce assertion failed");
// clocked on clk_i, also checked during reset
`define HCE_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("hce assertion failed");
`else
`define HCE_ASSERT(lbl, prop)
`define HCE_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// ===== sv/hce_pkg.sv =====
// ----------------------------------------------------------------------------
// Hysteresis comparator package
// Widths, register indexes, interrupt modes and the hysteresis table.
// ----------------------------------------------------------------------------
`default_nettype none

package hce_pkg;

  localparam int MV_BITS   = 13;
  localparam int HYST_BITS = 6;
  localparam int DAC_BITS  = 8;
  localparam int IN_BITS   = 3 * MV_BITS + 2;
  localparam int IN_TDATA  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS  = MV_BITS + 3;
  localparam int OUT_TDATA = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [1:0] {
    IRQ_BOTH = 2'd0,
    IRQ_NONE = 2'd1,
    IRQ_FALL = 2'd2,
    IRQ_RISE = 2'd3
  } int_mode_e;

  typedef enum logic [2:0] {
    REG_ENABLE     = 3'd0,
    REG_LOW_POWER  = 3'd1,
    REG_HYST_SEL   = 3'd2,
    REG_INT_MODE   = 3'd3,
    REG_INVERT_OUT = 3'd4,
    REG_INT_ENABLE = 3'd5,
    REG_DAC_LEVEL  = 3'd6,
    REG_SRC_SEL    = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic                enable;
    logic                low_power;
    logic [1:0]          hyst_select;
    int_mode_e           int_mode;
    logic                invert_out;
    logic                int_enable;
    logic [DAC_BITS-1:0] dac_level;
    logic [1:0]          source_select;
  } cfg_t;

  typedef struct packed {
    logic [MV_BITS-1:0] pos_mv;
    logic [MV_BITS-1:0] neg_mv;
    logic [MV_BITS-1:0] vref_mv;
    logic               paused;
    logic               flag_clr;
  } sample_t;

  typedef struct packed {
    logic [MV_BITS-1:0] dac_mv;
    logic               irq;
    logic               flag;
    logic               comp_out;
  } result_t;

  // hysteresis band half-width in mV
  function automatic logic [HYST_BITS-1:0] hyst_mv(input logic low_power,
                                                   input logic [1:0] sel);
    logic [HYST_BITS-1:0] h;
    unique case (sel)
      2'd0:    h = HYST_BITS'(0);
      2'd1:    h = HYST_BITS'(10);
      2'd2:    h = low_power ? HYST_BITS'(25) : HYST_BITS'(30);
      default: h = low_power ? HYST_BITS'(50) : HYST_BITS'(60);
    endcase
    return h;
  endfunction

endpackage

`default_nettype wire

// ===== sv/hysteresis_comparator_edge_irq_top.sv =====
// ----------------------------------------------------------------------------
// Hysteresis comparator with edge interrupt flag
// Stream wrapper: configuration registers, input register, result register.
// ----------------------------------------------------------------------------
// Takes one sample transfer per clock unless the output is stalled, and
// returns one result transfer per sample through the input register and
// then the result register. The rate is set by the state update (hysteresis,
// inversion, edge flag) between the input register and the result register.
// The user must write configuration through cfg_we_i/cfg_idx_i/cfg_data_i
// only while no sample is in flight; the block itself does not enforce this.
`default_nettype none

module hysteresis_comparator_edge_irq_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [2:0]                    cfg_idx_i,
  input  logic [hce_pkg::DAC_BITS-1:0]  cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // pos_mv, neg_mv, vref_mv, paused, flag_clr, zero pad
  input  logic [hce_pkg::IN_TDATA-1:0]  s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // comp_out, flag, irq, dac_mv
  output logic [hce_pkg::OUT_TDATA-1:0] m_axis_tdata
);
  import hce_pkg::*;

  cfg_t    cfg_q;
  logic    in_vld_q;
  sample_t in_q;
  sample_t in_d;
  logic    out_vld_q;
  result_t out_q;
  result_t res;
  logic    adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        REG_ENABLE:     cfg_q.enable        <= cfg_data_i[0];
        REG_LOW_POWER:  cfg_q.low_power     <= cfg_data_i[0];
        REG_HYST_SEL:   cfg_q.hyst_select   <= cfg_data_i[1:0];
        REG_INT_MODE:   cfg_q.int_mode      <= int_mode_e'(cfg_data_i[1:0]);
        REG_INVERT_OUT: cfg_q.invert_out    <= cfg_data_i[0];
        REG_INT_ENABLE: cfg_q.int_enable    <= cfg_data_i[0];
        REG_DAC_LEVEL:  cfg_q.dac_level     <= cfg_data_i;
        REG_SRC_SEL:    cfg_q.source_select <= cfg_data_i[1:0];
        default:        cfg_q               <= cfg_q;
      endcase
    end
  end

  assign in_d.pos_mv   = s_axis_tdata[MV_BITS-1:0];
  assign in_d.neg_mv   = s_axis_tdata[2*MV_BITS-1:MV_BITS];
  assign in_d.vref_mv  = s_axis_tdata[3*MV_BITS-1:2*MV_BITS];
  assign in_d.paused   = s_axis_tdata[3*MV_BITS];
  assign in_d.flag_clr = s_axis_tdata[3*MV_BITS+1];

  assign adv           = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_vld_q <= s_axis_tvalid;
      end
      if (adv) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_q <= in_d;
    end
    if (adv) begin
      out_q <= res;
    end
  end

  hce_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (adv),
    .sample_i (in_q),
    .cfg_i    (cfg_q),
    .result_o (res)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = OUT_TDATA'(out_q);

endmodule

`default_nettype wire

// ===== sv/hce_core.sv =====
// ----------------------------------------------------------------------------
// Hysteresis comparator core
// DAC, input select, hysteresis state, output inversion and edge flag.
// ----------------------------------------------------------------------------
`default_nettype none

`include "hysteresis_comparator_edge_irq_top_macros.svh"

module hce_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  hce_pkg::sample_t sample_i,
  input  hce_pkg::cfg_t    cfg_i,
  output hce_pkg::result_t result_o
);
  import hce_pkg::*;

  logic raw_q, raw_d;
  logic out_q, out_d;
  logic flag_q, flag_d;

  logic [MV_BITS+DAC_BITS-1:0] prod;
  logic [MV_BITS-1:0]          dac;
  logic [MV_BITS-1:0]          p_mv, n_mv;
  logic signed [MV_BITS:0]     diff;
  logic signed [MV_BITS:0]     h_pos, h_neg;
  logic                        raw_nx, out_nx, edge_hit;

  assign prod = (MV_BITS+DAC_BITS)'(sample_i.vref_mv) * (MV_BITS+DAC_BITS)'(cfg_i.dac_level);
  assign dac  = prod[MV_BITS+DAC_BITS-1:DAC_BITS];

  assign p_mv  = cfg_i.source_select[0] ? dac : sample_i.pos_mv;
  assign n_mv  = cfg_i.source_select[1] ? dac : sample_i.neg_mv;
  assign diff  = $signed({1'b0, p_mv}) - $signed({1'b0, n_mv});
  assign h_pos = $signed({{(MV_BITS+1-HYST_BITS){1'b0}},
                          hyst_mv(cfg_i.low_power, cfg_i.hyst_select)});
  assign h_neg = -h_pos;

  always_comb begin
    raw_nx = raw_q;
    if (raw_q && (diff < h_neg)) begin
      raw_nx = 1'b0;
    end else if (!raw_q && (diff > h_pos)) begin
      raw_nx = 1'b1;
    end
    out_nx = raw_nx ^ cfg_i.invert_out;
    unique case (cfg_i.int_mode)
      IRQ_BOTH: edge_hit = out_nx != out_q;
      IRQ_FALL: edge_hit = out_q && !out_nx;
      IRQ_RISE: edge_hit = !out_q && out_nx;
      default:  edge_hit = 1'b0;
    endcase
  end

  always_comb begin
    raw_d  = raw_q;
    out_d  = out_q;
    flag_d = flag_q;
    if (!sample_i.paused) begin
      if (sample_i.flag_clr) begin
        flag_d = 1'b0;
      end
      if (cfg_i.enable) begin
        raw_d = raw_nx;
        out_d = out_nx;
        if (edge_hit) begin
          flag_d = 1'b1;
        end
      end else begin
        raw_d = 1'b0;
        out_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_q  <= 1'b0;
      out_q  <= 1'b0;
      flag_q <= 1'b0;
    end else if (step_i) begin
      raw_q  <= raw_d;
      out_q  <= out_d;
      flag_q <= flag_d;
    end
  end

  assign result_o.comp_out = out_d;
  assign result_o.flag     = flag_d;
  assign result_o.irq      = flag_d & cfg_i.int_enable;
  assign result_o.dac_mv   = dac;

  `HCE_ASSERT(a_paused_holds,
    step_i && sample_i.paused |=> $stable(raw_q) && $stable(out_q) && $stable(flag_q))
  `HCE_ASSERT(a_disabled_clears,
    step_i && !sample_i.paused && !cfg_i.enable |=> !raw_q && !out_q)
  `HCE_ASSERT(a_out_tracks_raw,
    step_i && !sample_i.paused && cfg_i.enable |=> out_q == (raw_q ^ $past(cfg_i.invert_out)))
  `HCE_ASSERT_ALWAYS(a_idle_holds,
    rst_ni && $past(rst_ni) && !$past(step_i) |-> $stable(flag_q))

endmodule

`default_nettype wire
